>>> hdl/cbfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbfd_pkg
// Shared types and constants for the cubic B-spline forward differencing
// block.
// ----------------------------------------------------------------------------
package cbfd_pkg;

  localparam int SHIFT_W = 3;

  typedef struct packed {
    logic load;
    logic step;
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> hdl/cbfd_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbfd_cell
// One forward difference cell: loads a start value, then adds the value of
// its right-hand neighbor on every step.
// ----------------------------------------------------------------------------
module cbfd_cell #(
  parameter int W = 48
) (
  input  wire                   clk,
  input  wire cbfd_pkg::cell_ctl_t ctl,
  input  wire  [W-1:0]          init,
  input  wire  [W-1:0]          nb,
  output logic [W-1:0]          val
);
  import cbfd_pkg::*;

  logic [W-1:0] val_r;
  logic [W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctl.load) begin
      val_nxt = init;
    end else if (ctl.step) begin
      val_nxt = val_r + nb;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule
`default_nettype wire

>>> hdl/cbfd_setup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbfd_setup
// Segment setup for one axis: captures the basis coefficients A, B, C, D of
// a segment and scales them into the start values of the difference cells.
// ----------------------------------------------------------------------------
module cbfd_setup #(
  parameter int CW = 16,
  parameter int AW = 48
) (
  input  wire                             clk,
  input  wire                             capture,
  input  wire  signed [CW-1:0]            w0,
  input  wire  signed [CW-1:0]            w1,
  input  wire  signed [CW-1:0]            w2,
  input  wire  signed [CW-1:0]            p3,
  input  wire  [cbfd_pkg::SHIFT_W-1:0]    k,
  output logic [3:0][AW-1:0]              init
);
  import cbfd_pkg::*;

  localparam int CF = CW + 4;

  logic signed [CF-1:0] e0, e1, e2, e3;
  logic signed [CF-1:0] a_nxt, b_nxt, c_nxt, d_nxt;
  logic signed [CF-1:0] a_r, b_r, c_r, d_r;
  logic signed [AW-1:0] a_x, b_x, c_x, d_x;
  logic [SHIFT_W:0]     k2;
  logic [SHIFT_W+1:0]   k3;

  assign e0 = CF'(w0);
  assign e1 = CF'(w1);
  assign e2 = CF'(w2);
  assign e3 = CF'(p3);

  always_comb begin
    a_nxt = e3 - e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2;
    b_nxt = (e0 <<< 1) + e0 - (e1 <<< 2) - (e1 <<< 1) + (e2 <<< 1) + e2;
    c_nxt = (e2 <<< 1) + e2 - (e0 <<< 1) - e0;
    d_nxt = e0 + (e1 <<< 2) + e2;
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
      d_r <= d_nxt;
    end
  end

  assign a_x = AW'(a_r);
  assign b_x = AW'(b_r);
  assign c_x = AW'(c_r);
  assign d_x = AW'(d_r);
  assign k2  = {k, 1'b0};
  assign k3  = {1'b0, k2} + {2'b00, k};

  always_comb begin
    init[0] = d_x <<< k3;
    init[1] = a_x + (b_x <<< k) + (c_x <<< k2);
    init[2] = (a_x <<< 2) + (a_x <<< 1) + (b_x <<< (k + 1'b1));
    init[3] = (a_x <<< 2) + (a_x <<< 1);
  end

endmodule
`default_nettype wire

>>> hdl/cbfd_round.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbfd_round
// Output scaling for one axis: adds half a unit, divides by 6 * 2^(3k) with
// floor, and saturates to the coordinate range. Three register stages.
// ----------------------------------------------------------------------------
module cbfd_round #(
  parameter int CW = 16,
  parameter int AW = 48
) (
  input  wire                           clk,
  input  wire                           en,
  input  wire  [cbfd_pkg::SHIFT_W-1:0]  k,
  input  wire  [AW-1:0]                 f,
  output logic [CW-1:0]                 coord
);
  import cbfd_pkg::*;

  localparam int QW  = AW + 2;
  localparam int XW  = CW + 2;
  localparam int NSH = CW + 4;
  localparam int RW  = CW + 3;
  localparam int PW  = XW + RW;
  localparam logic [RW-1:0]        RECIP = RW'((2 ** NSH + 2) / 3);
  localparam logic signed [QW-1:0] OFF   = QW'(3 * 2 ** (CW - 1));
  localparam logic signed [QW-1:0] XMAX_Q = QW'(3 * 2 ** CW - 1);
  localparam logic [XW-1:0]        XMAX  = XW'(3 * 2 ** CW - 1);

  logic [SHIFT_W+1:0]   k3;
  logic [SHIFT_W+1:0]   sh;
  logic signed [QW-1:0] half;
  logic signed [QW-1:0] fe;
  logic signed [QW-1:0] sum;
  logic signed [QW-1:0] q_nxt, q_r;
  logic signed [QW-1:0] t;
  logic [XW-1:0]        x_nxt, x_r;
  logic [PW-1:0]        prod_nxt, prod_r;

  assign k3   = {1'b0, k, 1'b0} + {2'b00, k};
  assign sh   = k3 + 1'b1;
  assign half = QW'(3) <<< k3;
  assign fe   = $signed({{2{f[AW-1]}}, f});
  assign sum  = fe + half;
  assign q_nxt = sum >>> sh;

  always_comb begin
    t = q_r + OFF;
    if (t < 0) begin
      x_nxt = '0;
    end else if (t > XMAX_Q) begin
      x_nxt = XMAX;
    end else begin
      x_nxt = t[XW-1:0];
    end
  end

  assign prod_nxt = PW'(x_r) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      q_r    <= q_nxt;
      x_r    <= x_nxt;
      prod_r <= prod_nxt;
    end
  end

  assign coord = {~prod_r[NSH+CW-1], prod_r[NSH +: CW-1]};

endmodule
`default_nettype wire

>>> hdl/cubic_bspline_forward_diff.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_bspline_forward_diff
// Uniform cubic B-spline evaluator: keeps the last three control points and,
// for each completed segment, emits 2^k curve points by forward differencing.
// A completed segment is loaded into the difference cells and stepped 2^k
// times; curve points leave one per cycle while out_ready allows, and no new
// control point is taken until the last step of the segment has issued.
// Points that do not complete a segment only shift the control point window.
// Reset: synchronous, active low; clears the held point count, the step count
// and the pipeline valid bits, and sets the step shift to its maximum.
// ----------------------------------------------------------------------------
module cubic_bspline_forward_diff #(
  parameter int COORD_WIDTH    = 16,
  parameter int MAX_STEP_SHIFT = 6,
  parameter int ACC_WIDTH      = 48
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  signed [COORD_WIDTH-1:0]      in_point_x,
  input  wire  signed [COORD_WIDTH-1:0]      in_point_y,
  input  wire                                in_first,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic signed [COORD_WIDTH-1:0]      out_curve_x,
  output logic signed [COORD_WIDTH-1:0]      out_curve_y,
  output logic                               out_last,
  input  wire                                cfg_wr_en,
  input  wire  [cbfd_pkg::SHIFT_W-1:0]       cfg_wr_data
);
  import cbfd_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int AW   = ACC_WIDTH;
  localparam int SL_W = MAX_STEP_SHIFT + 1;
  localparam logic [SHIFT_W-1:0] K_MAX = SHIFT_W'(MAX_STEP_SHIFT);
  localparam logic [SHIFT_W-1:0] K_MIN = SHIFT_W'(1);

  logic [SHIFT_W-1:0]   k_r, k_nxt;
  logic [1:0]           held_r, held_nxt, held_eff;
  logic                 load_r, load_nxt;
  logic [SL_W-1:0]      steps_r, steps_nxt;
  logic                 s0_v_r, s0_last_r, va_r, la_r, vb_r, lb_r, vc_r, lc_r;
  logic                 out_valid_r, out_last_r;
  logic [CW-1:0]        out_x_r, out_y_r;

  logic                 in_fire, seg_start, adv, load_go, step_go;
  cell_ctl_t            ctl;

  logic signed [CW-1:0] pt    [2];
  logic signed [CW-1:0] win_r [2][3];
  logic [3:0][AW-1:0]   init  [2];
  logic [AW-1:0]        diff  [2][4];
  logic [AW-1:0]        nb    [2][4];
  logic [CW-1:0]        coord [2];

  assign pt[0] = in_point_x;
  assign pt[1] = in_point_y;

  assign in_ready  = !load_r && (steps_r == '0);
  assign in_fire   = in_valid && in_ready;
  assign held_eff  = in_first ? 2'd0 : held_r;
  assign seg_start = in_fire && (held_eff == 2'd3);
  assign adv       = !out_valid_r || out_ready;
  assign load_go   = load_r && (!s0_v_r || adv);
  assign step_go   = adv && (steps_r != '0);
  assign ctl.load  = load_go;
  assign ctl.step  = step_go;

  always_comb begin
    k_nxt = k_r;
    if (cfg_wr_en) begin
      if (cfg_wr_data < K_MIN) begin
        k_nxt = K_MIN;
      end else if (cfg_wr_data > K_MAX) begin
        k_nxt = K_MAX;
      end else begin
        k_nxt = cfg_wr_data;
      end
    end
  end

  always_comb begin
    held_nxt  = held_r;
    load_nxt  = load_r;
    steps_nxt = steps_r;
    if (in_fire) begin
      held_nxt = (held_eff == 2'd3) ? 2'd3 : held_eff + 2'd1;
    end
    if (seg_start) begin
      load_nxt = 1'b1;
    end
    if (load_go) begin
      load_nxt  = 1'b0;
      steps_nxt = SL_W'(1) << k_r;
    end else if (step_go) begin
      steps_nxt = steps_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= K_MAX;
      held_r  <= 2'd0;
      load_r  <= 1'b0;
      steps_r <= '0;
    end else begin
      k_r     <= k_nxt;
      held_r  <= held_nxt;
      load_r  <= load_nxt;
      steps_r <= steps_nxt;
    end
  end

  // shift the window
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int a = 0; a < 2; a++) begin
        win_r[a][0] <= win_r[a][1];
        win_r[a][1] <= win_r[a][2];
        win_r[a][2] <= pt[a];
      end
    end
  end

  // advance the valid and last flags alongside the rounding stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r      <= 1'b0;
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s0_v_r      <= step_go;
      va_r        <= s0_v_r;
      vb_r        <= va_r;
      vc_r        <= vb_r;
      out_valid_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_last_r  <= (steps_r == SL_W'(1));
      la_r       <= s0_last_r;
      lb_r       <= la_r;
      lc_r       <= lb_r;
      out_last_r <= lc_r;
      out_x_r    <= coord[0];
      out_y_r    <= coord[1];
    end
  end

  for (genvar a = 0; a < 2; a++) begin : g_axis
    cbfd_setup #(
      .CW (CW),
      .AW (AW)
    ) u_setup (
      .clk     (clk),
      .capture (seg_start),
      .w0      (win_r[a][0]),
      .w1      (win_r[a][1]),
      .w2      (win_r[a][2]),
      .p3      (pt[a]),
      .k       (k_r),
      .init    (init[a])
    );

    for (genvar i = 0; i < 4; i++) begin : g_cell
      if (i < 3) begin : g_mid
        assign nb[a][i] = diff[a][i+1];
      end else begin : g_end
        assign nb[a][i] = '0;
      end

      cbfd_cell #(
        .W (AW)
      ) u_cell (
        .clk  (clk),
        .ctl  (ctl),
        .init (init[a][i]),
        .nb   (nb[a][i]),
        .val  (diff[a][i])
      );
    end

    cbfd_round #(
      .CW (CW),
      .AW (AW)
    ) u_round (
      .clk   (clk),
      .en    (adv),
      .k     (k_r),
      .f     (diff[a][0]),
      .coord (coord[a])
    );
  end

  assign out_valid   = out_valid_r;
  assign out_last    = out_last_r;
  assign out_curve_x = out_x_r;
  assign out_curve_y = out_y_r;

endmodule
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for cubic_bspline_forward_diff. A table of directed
// control points (extreme coordinates, constant segments, restarts on a full
// and a partial window) runs at the reset step shift. Random curves then run
// in phases, each with its own step shift and its own idle and stall rates.
// A behavioral forward differencing model predicts unfixed curve points, and
// each output transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import cbfd_pkg::*;

  localparam int CW             = 16;
  localparam int MAX_SHIFT      = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 10;
  localparam int MAX_REPORTS    = 40;
  localparam int N_ROWS         = 20;
  localparam int N_PHASES       = 8;
  localparam int HOLD_PHASE     = 3;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 last;
  } curve_pt_t;

  typedef struct {
    int x;
    int y;
    bit first;
    bit fixed;
    int fx;
    int fy;
  } ctl_row_t;

  typedef struct {
    int shift;
    int idle_pct;
    int stall_pct;
    int points;
  } phase_t;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  logic signed [CW-1:0] in_point_x  = '0;
  logic signed [CW-1:0] in_point_y  = '0;
  logic                 in_first    = 1'b0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  logic signed [CW-1:0] out_curve_x;
  logic signed [CW-1:0] out_curve_y;
  logic                 out_last;
  logic                 cfg_wr_en   = 1'b0;
  logic [SHIFT_W-1:0]   cfg_wr_data = '0;

  curve_pt_t curve_q[$];
  longint    win_x[3];
  longint    win_y[3];
  int        held       = 0;
  int        shift_k    = MAX_SHIFT;
  int        idle_pct   = 0;
  int        stall_pct  = 0;
  int        errors     = 0;
  int        quiet_cycles = 0;

  ctl_row_t ctl_rows [N_ROWS] = '{
    '{ 32767,  32767, 1, 0,      0,      0},
    '{ 32767,  32767, 0, 0,      0,      0},
    '{ 32767,  32767, 0, 0,      0,      0},
    '{ 32767,  32767, 0, 1,  32767,  32767},
    '{-32768, -32768, 1, 0,      0,      0},
    '{-32768, -32768, 0, 0,      0,      0},
    '{-32768, -32768, 0, 0,      0,      0},
    '{-32768, -32768, 0, 1, -32768, -32768},
    '{ 32767, -32768, 0, 0,      0,      0},
    '{-32768,  32767, 0, 0,      0,      0},
    '{ 32767, -32768, 0, 0,      0,      0},
    '{     0,      0, 0, 0,      0,      0},
    '{    -1,      1, 1, 0,      0,      0},
    '{    -1,      1, 0, 0,      0,      0},
    '{   100,   -100, 1, 0,      0,      0},
    '{   100,   -100, 0, 0,      0,      0},
    '{   100,   -100, 0, 0,      0,      0},
    '{   100,   -100, 0, 1,    100,   -100},
    '{-21846,  21845, 0, 0,      0,      0},
    '{ 21845, -21846, 0, 0,      0,      0}
  };

  phase_t phases [N_PHASES] = '{
    '{0,  0,  0, 20},
    '{7, 59,  0, 20},
    '{1,  0, 59, 20},
    '{3, 30, 30, 20},
    '{6,  0,  0, 10},
    '{2, 59,  0, 20},
    '{5,  0, 59, 20},
    '{4, 30, 30, 20}
  };

  cubic_bspline_forward_diff u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_point_x  (in_point_x),
    .in_point_y  (in_point_y),
    .in_first    (in_first),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_curve_x (out_curve_x),
    .out_curve_y (out_curve_y),
    .out_last    (out_last),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #1 clk = ~clk;

  function automatic longint wrap_acc(input longint v);
    return (v <<< 16) >>> 16;
  endfunction

  function automatic void seed_diffs(input longint w0, input longint w1, input longint w2,
                                     input longint p3, input int k,
                                     output longint f, output longint d1,
                                     output longint d2, output longint d3);
    longint a, b, c, d, u1, u2, u3;
    a  = -w0 + 3 * w1 - 3 * w2 + p3;
    b  = 3 * w0 - 6 * w1 + 3 * w2;
    c  = -3 * w0 + 3 * w2;
    d  = w0 + 4 * w1 + w2;
    u1 = longint'(1) << k;
    u2 = longint'(1) << (2 * k);
    u3 = longint'(1) << (3 * k);
    f  = wrap_acc(d * u3);
    d1 = wrap_acc(a + b * u1 + c * u2);
    d2 = wrap_acc(6 * a + 2 * b * u1);
    d3 = wrap_acc(6 * a);
  endfunction

  function automatic void advance_diffs(inout longint f, inout longint d1,
                                        inout longint d2, input longint d3);
    f  = wrap_acc(f + d1);
    d1 = wrap_acc(d1 + d2);
    d2 = wrap_acc(d2 + d3);
  endfunction

  function automatic logic signed [CW-1:0] round_coord(input longint f, input int k);
    longint s, r, q, lim;
    s   = longint'(6) << (3 * k);
    r   = f + s / 2;
    q   = r / s;
    lim = longint'(1) << (CW - 1);
    if (r < 0 && q * s != r) q = q - 1;
    if (q < -lim) q = -lim;
    if (q > lim - 1) q = lim - 1;
    return q[CW-1:0];
  endfunction

  task automatic take_control_point(input int x, input int y, input bit first,
                                    input bit fixed, input int fx, input int fy);
    longint    ax[4];
    longint    ay[4];
    curve_pt_t pt;
    int        n;
    if (first) held = 0;
    if (held >= 3) begin
      seed_diffs(win_x[0], win_x[1], win_x[2], x, shift_k, ax[0], ax[1], ax[2], ax[3]);
      seed_diffs(win_y[0], win_y[1], win_y[2], y, shift_k, ay[0], ay[1], ay[2], ay[3]);
      n = 1 << shift_k;
      for (int j = 0; j < n; j++) begin
        advance_diffs(ax[0], ax[1], ax[2], ax[3]);
        advance_diffs(ay[0], ay[1], ay[2], ay[3]);
        pt.last = (j == n - 1);
        if (fixed) begin
          pt.x = fx[CW-1:0];
          pt.y = fy[CW-1:0];
        end else begin
          pt.x = round_coord(ax[0], shift_k);
          pt.y = round_coord(ay[0], shift_k);
        end
        curve_q.insert(curve_q.size(), pt);
      end
    end
    win_x[0] = win_x[1];
    win_x[1] = win_x[2];
    win_x[2] = x;
    win_y[0] = win_y[1];
    win_y[1] = win_y[2];
    win_y[2] = y;
    if (held < 3) held++;
  endtask

  task automatic send_point(input int x, input int y, input bit first,
                            input bit fixed, input int fx, input int fy);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_point_x <= x[CW-1:0];
    in_point_y <= y[CW-1:0];
    in_first   <= first;
    do @(posedge clk); while (!in_ready);
    take_control_point(x, y, first, fixed, fx, fy);
    @(negedge clk);
  endtask

  task automatic drain_curve();
    in_valid <= 1'b0;
    do @(negedge clk); while (curve_q.size() != 0);
  endtask

  task automatic write_step_shift(input int v);
    drain_curve();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v[SHIFT_W-1:0];
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    shift_k = (v < 1) ? 1 : ((v > MAX_SHIFT) ? MAX_SHIFT : v);
  endtask

  function automatic int random_coord();
    case ($urandom_range(0, 9))
      0:       return 32767;
      1:       return -32768;
      2, 3:    return int'($urandom_range(0, 127)) - 64;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : check_curve
    curve_pt_t want;
    if (rst_n && out_valid && out_ready) begin
      if (curve_q.size() == 0) begin
        report_mismatch("unexpected curve point x", out_curve_x, 0);
      end else begin
        want = curve_q.pop_front();
        if (out_curve_x !== want.x) report_mismatch("curve_x", out_curve_x, want.x);
        if (out_curve_y !== want.y) report_mismatch("curve_y", out_curve_y, want.y);
        if (out_last !== want.last) report_mismatch("last", out_last, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int     curve_left;
    bit     start;
    phase_t ph;
    curve_left = 0;
    for (int i = 0; i < 3; i++) begin
      win_x[i] = 0;
      win_y[i] = 0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (ctl_rows[r])
      send_point(ctl_rows[r].x, ctl_rows[r].y, ctl_rows[r].first,
                 ctl_rows[r].fixed, ctl_rows[r].fx, ctl_rows[r].fy);

    for (int p = 0; p < N_PHASES; p++) begin
      ph = phases[p];
      write_step_shift(ph.shift);
      idle_pct  = ph.idle_pct;
      stall_pct = ph.stall_pct;
      for (int i = 0; i < ph.points; i++) begin
        if (p == HOLD_PHASE && i == ph.points / 2) drain_curve();
        if (curve_left == 0) begin
          if ($urandom_range(0, 99) < 15) begin
            send_point(random_coord(), random_coord(), $urandom_range(0, 1), 0, 0, 0);
          end else begin
            curve_left = $urandom_range(4, 9);
            start = 1'b1;
          end
        end
        if (curve_left != 0) begin
          send_point(random_coord(), random_coord(), start, 0, 0, 0);
          start = 1'b0;
          curve_left--;
        end
      end
    end

    drain_curve();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
